FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the comb reverb.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define CMBR_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define CMBR_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// Condition that must hold at every edge, reset included.
`define CMBR_ASSERT_ALW(lbl, ck, cond, msg) \
	lbl: assert property (@(posedge ck) (cond)) else $error(msg);

`endif

FILE: rtl/cmbr_pkg.sv
// Shared constants and types of the multi-tap feedback comb reverb.
// No dependencies; imported by every module of the block.
package cmbr_pkg;

	localparam int DEF_HISTORY_DEPTH = 4096;
	localparam int DEF_TAP_COUNT     = 3;
	localparam int DEF_SAMPLE_BITS   = 16;

	localparam int COEFF_W     = 16;
	localparam int DELAY_W     = 12;
	localparam int CFG_DATA_W  = 16;
	localparam int FRAC_SHIFT  = 15;
	localparam int HIST_GUARD  = 4;
	localparam int RECIP_SHIFT = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_TAPS    = 8;

	localparam int CFG_IDX_GAIN   = 0;
	localparam int CFG_IDX_DELAY0 = 1;

	localparam logic signed [COEFF_W-1:0] GAIN_RESET = 16'sd16384;

	localparam logic [DELAY_W-1:0] TAP_DELAY_RESET [MAX_TAPS] = '{
		12'd1009, 12'd2011, 12'd3001, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
	};

	localparam logic signed [COEFF_W-1:0] TAP_COEFF_RESET [MAX_TAPS] = '{
		16'sd13107, 16'sd9830, 16'sd6554, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
	};

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TAP,
		BK_DRAIN
	} back_state_t;

endpackage

FILE: rtl/multitap_feedback_comb_reverb.sv
// Multi-tap feedback comb reverb, top level. Depends on cmbr_pkg, cmbr_front,
// cmbr_fifo and cmbr_back.
//
// One input beat on s_axis carries a signed sample; one output beat on m_axis
// carries gain*x plus the sum of each tap coefficient times the history entry
// written that tap's delay ago, rounded and saturated; tuser flags saturation
// of the output or of the stored history entry.
// Registers are written through cfg_we/cfg_addr/cfg_wdata: index 0 is the
// input gain, then the tap delays, then the tap coefficients. Write them only
// while no sample is in flight.
// An accepted input beat passes the front pipeline registers and the queue.
// The back end works one sample at a time: the single read port of the history
// memory is used once per tap, then the multiply-accumulate pipe drains, and
// only then is the next sample taken from the queue. The front stage and a
// four-entry queue keep taking input beats meanwhile.
// When the receiver stalls, the result is held in the output register and
// the queue fills before s_axis_tready falls.
// Reset restores the register defaults, empties every stage and sets the
// write position to zero; history entries not yet written read as zero, so no
// clearing pass is needed.
module multitap_feedback_comb_reverb #(
	parameter int HISTORY_DEPTH = cmbr_pkg::DEF_HISTORY_DEPTH,
	parameter int TAP_COUNT     = cmbr_pkg::DEF_TAP_COUNT,
	parameter int SAMPLE_BITS   = cmbr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [SAMPLE_BITS-1:0] sample_in, upper bits unused
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [SAMPLE_BITS-1:0] sample_out, upper bits zero
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// [0] clipped
	output logic                                m_axis_tuser,
	input  logic                                cfg_we,
	input  logic [$clog2(2 * TAP_COUNT + 1)-1:0] cfg_addr,
	input  logic [cmbr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import cmbr_pkg::*;

	localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
	localparam int IDX_W   = $clog2(2 * TAP_COUNT + 1);
	localparam int ITEM_W  = SAMPLE_BITS + TAP_COUNT * ADDR_W;

	logic signed [COEFF_W-1:0] gain_q;
	logic [DELAY_W-1:0]        delay_q [TAP_COUNT];
	logic signed [COEFF_W-1:0] coeff_q [TAP_COUNT];

	logic              push, push_ready, q_valid, q_pop;
	logic [ITEM_W-1:0] push_data, q_data;
	logic signed [SAMPLE_BITS-1:0] out_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we && cfg_addr == IDX_W'(CFG_IDX_GAIN)) begin
			gain_q <= cfg_wdata[COEFF_W-1:0];
		end
	end

	for (genvar g = 0; g < TAP_COUNT; g++) begin : g_tap_regs
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				delay_q[g] <= TAP_DELAY_RESET[g];
				coeff_q[g] <= TAP_COEFF_RESET[g];
			end else if (cfg_we) begin
				if (cfg_addr == IDX_W'(CFG_IDX_DELAY0 + g)) begin
					delay_q[g] <= cfg_wdata[DELAY_W-1:0];
				end
				if (cfg_addr == IDX_W'(CFG_IDX_DELAY0 + TAP_COUNT + g)) begin
					coeff_q[g] <= cfg_wdata[COEFF_W-1:0];
				end
			end
		end
	end

	cmbr_front #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.TAP_COUNT     (TAP_COUNT),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
		.tap_delay  (delay_q),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cmbr_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_data   (q_data)
	);

	cmbr_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.TAP_COUNT     (TAP_COUNT),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_data),
		.input_gain  (gain_q),
		.tap_coeff   (coeff_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_sample  (out_sample),
		.out_clipped (m_axis_tuser)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[SAMPLE_BITS-1:0] = out_sample;
	end

endmodule

FILE: rtl/cmbr_front.sv
// Front end of the comb reverb: takes sample beats and reduces each tap delay
// modulo the history depth. Depends on cmbr_pkg.
module cmbr_front #(
	parameter int HISTORY_DEPTH = cmbr_pkg::DEF_HISTORY_DEPTH,
	parameter int TAP_COUNT     = cmbr_pkg::DEF_TAP_COUNT,
	parameter int SAMPLE_BITS   = cmbr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     in_sample,
	input  logic [cmbr_pkg::DELAY_W-1:0]      tap_delay [TAP_COUNT],
	output logic                              push,
	input  logic                              push_ready,
	output logic [SAMPLE_BITS+TAP_COUNT*$clog2(HISTORY_DEPTH)-1:0] push_data
);
	import cmbr_pkg::*;

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	// Reciprocal scaled by 2^RECIP_SHIFT, rounded up; exact quotient for 12-bit delays.
	localparam int RECIP  = (2**RECIP_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
	localparam int PROD_W = RECIP_SHIFT + DELAY_W;
	localparam int QD_W   = DELAY_W + ADDR_W + 1;

	logic                     adv;
	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [SAMPLE_BITS-1:0] x_s1, x_s2, x_s3;
	logic [PROD_W-1:0]        prod_s2 [TAP_COUNT];
	logic [ADDR_W-1:0]        dmod_s3 [TAP_COUNT];
	logic [QD_W-1:0]          rem     [TAP_COUNT];

	assign adv      = !valid_s3 || push_ready;
	assign in_ready = adv;
	assign push     = valid_s3;

	always_comb begin
		for (int i = 0; i < TAP_COUNT; i++) begin
			rem[i] = QD_W'(tap_delay[i])
				- QD_W'(prod_s2[i][RECIP_SHIFT +: DELAY_W]) * QD_W'(HISTORY_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= in_sample;
			x_s2 <= x_s1;
			x_s3 <= x_s2;
			for (int i = 0; i < TAP_COUNT; i++) begin
				prod_s2[i] <= PROD_W'(tap_delay[i]) * PROD_W'(RECIP);
				dmod_s3[i] <= rem[i][ADDR_W-1:0];
			end
		end
	end

	always_comb begin
		push_data = '0;
		push_data[SAMPLE_BITS-1:0] = x_s3;
		for (int i = 0; i < TAP_COUNT; i++) begin
			push_data[SAMPLE_BITS + i*ADDR_W +: ADDR_W] = dmod_s3[i];
		end
	end

endmodule

FILE: rtl/cmbr_fifo.sv
// Short queue between the front and the back of the comb reverb.
// Depends on cmbr_pkg for its default depth.
module cmbr_fifo #(
	parameter int WIDTH = cmbr_pkg::DEF_SAMPLE_BITS,
	parameter int DEPTH = cmbr_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);
	import cmbr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/cmbr_back.sv
// Back end of the comb reverb: history memory, shared tap multiply-accumulate,
// rounding, saturation and the output register. Depends on cmbr_pkg.
module cmbr_back #(
	parameter int HISTORY_DEPTH = cmbr_pkg::DEF_HISTORY_DEPTH,
	parameter int TAP_COUNT     = cmbr_pkg::DEF_TAP_COUNT,
	parameter int SAMPLE_BITS   = cmbr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                q_pop,
	input  logic [SAMPLE_BITS+TAP_COUNT*$clog2(HISTORY_DEPTH)-1:0] q_data,
	input  logic signed [cmbr_pkg::COEFF_W-1:0] input_gain,
	input  logic signed [cmbr_pkg::COEFF_W-1:0] tap_coeff [TAP_COUNT],
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_BITS-1:0]       out_sample,
	output logic                                out_clipped
);
	import cmbr_pkg::*;

	localparam int ADDR_W = $clog2(HISTORY_DEPTH);
	localparam int TAP_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int HIST_W = SAMPLE_BITS + HIST_GUARD;
	localparam int PROD_W = HIST_W + COEFF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT + 1);
	localparam int RND_W  = ACC_W + 1;
	localparam int SUM_W  = RND_W - FRAC_SHIFT;

	localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(2**(FRAC_SHIFT - 1));
	localparam logic signed [SUM_W-1:0] HIST_MAX = SUM_W'(2**(HIST_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] HIST_MIN = SUM_W'(-(2**(HIST_W - 1)));
	localparam logic signed [SUM_W-1:0] SMP_MAX  = SUM_W'(2**(SAMPLE_BITS - 1) - 1);
	localparam logic signed [SUM_W-1:0] SMP_MIN  = SUM_W'(-(2**(SAMPLE_BITS - 1)));

	back_state_t state_q, state_nx;

	logic [TAP_W-1:0]  tap_q;
	logic [ADDR_W-1:0] wp_q;
	logic              filled_q;
	logic [ADDR_W-1:0] dmod_q [TAP_COUNT];

	logic signed [SAMPLE_BITS-1:0] item_x;
	logic [ADDR_W-1:0] item_dmod [TAP_COUNT];

	logic [ADDR_W-1:0] rd_dm, rd_addr;
	logic              rd_ge, rd_hv;

	logic                     rd_vld_s1, hv_s1;
	logic [TAP_W-1:0]         tap_s1;
	logic signed [HIST_W-1:0] rdata_s1, hist_s1;

	logic                     prod_vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic signed [RND_W-1:0]       rnd;
	logic signed [SUM_W-1:0]       sum;
	logic signed [HIST_W-1:0]      hist_new;
	logic signed [SAMPLE_BITS-1:0] smp_new;
	logic                          clip_new;

	logic pipe_busy, out_free, issue, pop, finish, last_tap;

	logic [HIST_W-1:0] hist_mem [HISTORY_DEPTH];

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          clip_q;

	always_comb begin
		item_x = q_data[SAMPLE_BITS-1:0];
		for (int i = 0; i < TAP_COUNT; i++) begin
			item_dmod[i] = q_data[SAMPLE_BITS + i*ADDR_W +: ADDR_W];
		end
	end

	assign pipe_busy = rd_vld_s1 || prod_vld_s2;
	assign out_free  = !out_valid_q || out_ready;
	assign last_tap  = tap_q == TAP_W'(TAP_COUNT - 1);
	assign q_pop     = pop;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) state_nx = BK_TAP;
			end
			BK_TAP: begin
				if (last_tap) state_nx = BK_DRAIN;
			end
			BK_DRAIN: begin
				if (finish) state_nx = q_valid ? BK_TAP : BK_IDLE;
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// The next item is popped in the same cycle that the previous one retires.
	always_comb begin
		issue  = 1'b0;
		pop    = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = q_valid;
			BK_TAP:  issue = 1'b1;
			BK_DRAIN: begin
				finish = !pipe_busy && out_free;
				pop    = finish && q_valid;
			end
			default: ;
		endcase
	end

	// Tap position behind the write position, wrapping at the depth. An entry
	// not yet written since reset reads as zero.
	always_comb begin
		rd_dm   = dmod_q[tap_q];
		rd_ge   = wp_q >= rd_dm;
		rd_addr = rd_ge ? wp_q - rd_dm
			: ADDR_W'({1'b0, wp_q} + (ADDR_W + 1)'(HISTORY_DEPTH) - {1'b0, rd_dm});
		rd_hv   = filled_q || (rd_ge && rd_dm != '0);
	end

	assign hist_s1 = hv_s1 ? rdata_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			tap_q       <= '0;
			wp_q        <= '0;
			filled_q    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			rd_vld_s1   <= issue;
			prod_vld_s2 <= pop || rd_vld_s1;
			if (pop) begin
				tap_q <= '0;
			end else if (issue) begin
				tap_q <= last_tap ? '0 : tap_q + 1'b1;
			end
			if (finish) begin
				if (wp_q == ADDR_W'(HISTORY_DEPTH - 1)) begin
					wp_q     <= '0;
					filled_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < TAP_COUNT; i++) begin
				dmod_q[i] <= item_dmod[i];
			end
			prod_s2 <= PROD_W'(input_gain) * PROD_W'(item_x);
			acc_q   <= '0;
		end else begin
			if (rd_vld_s1) begin
				prod_s2 <= PROD_W'(tap_coeff[tap_s1]) * PROD_W'(hist_s1);
			end
			if (prod_vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		if (issue) begin
			hv_s1  <= rd_hv;
			tap_s1 <= tap_q;
		end
		if (finish) begin
			sample_q <= smp_new;
			clip_q   <= clip_new;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hist_mem[wp_q] <= hist_new;
		end
		rdata_s1 <= hist_mem[rd_addr];
	end

	// Round half up: add half an LSB, then keep the upper bits (floor).
	always_comb begin
		rnd      = RND_W'(acc_q) + RND_HALF;
		sum      = rnd[RND_W-1:FRAC_SHIFT];
		clip_new = 1'b0;
		if (sum > HIST_MAX) begin
			hist_new = HIST_MAX[HIST_W-1:0];
			clip_new = 1'b1;
		end else if (sum < HIST_MIN) begin
			hist_new = HIST_MIN[HIST_W-1:0];
			clip_new = 1'b1;
		end else begin
			hist_new = sum[HIST_W-1:0];
		end
		if (sum > SMP_MAX) begin
			smp_new  = SMP_MAX[SAMPLE_BITS-1:0];
			clip_new = 1'b1;
		end else if (sum < SMP_MIN) begin
			smp_new  = SMP_MIN[SAMPLE_BITS-1:0];
			clip_new = 1'b1;
		end else begin
			smp_new = sum[SAMPLE_BITS-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = sample_q;
	assign out_clipped = clip_q;

endmodule

FILE: rtl/cmbr_checker.sv
// Port-level checks of the comb reverb and their bind to the top level.
// Depends on cmbr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cmbr_checker #(
	parameter int SAMPLE_BITS = cmbr_pkg::DEF_SAMPLE_BITS
) (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     s_axis_tvalid,
	input logic                                     s_axis_tready,
	input logic                                     m_axis_tvalid,
	input logic                                     m_axis_tready,
	input logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input logic                                     m_axis_tuser
);
	import cmbr_pkg::*;

	logic       in_beat, out_beat;
	logic [7:0] pending_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// Samples taken in whose result beat has not gone out yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// Before the first edge under reset the output register may still be unknown.
	`CMBR_ASSERT_ALW(a_idle_in_reset, clk, arst_n !== 1'b0 || m_axis_tvalid !== 1'b1, "output valid during reset")

	`CMBR_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output beat changed")

	`CMBR_ASSERT_IMP(a_no_orphan, clk, arst_n, m_axis_tvalid, pending_q != '0, "output beat without a pending sample")

	`CMBR_ASSERT_NXT(a_min_latency, clk, arst_n, in_beat && pending_q == '0, !m_axis_tvalid, "result appeared one cycle after input")

endmodule

bind multitap_feedback_comb_reverb cmbr_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_cmbr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
